// File: hw/rtl/swg_pkg.sv
// ----------------------------------------------------------------------------
// swg_pkg
// Shared types, constants and tables for the spiral waypoint generator.
// ----------------------------------------------------------------------------
package swg_pkg;

   // Turn counter width and CORDIC iteration count
   localparam int TURN_COUNT_BITS = 16;
   localparam int SINCOS_STEPS    = 24;

   localparam int FRAC_BITS  = 32;
   localparam int PHASE_BITS = TURN_COUNT_BITS + FRAC_BITS;
   localparam int RAD_BITS   = TURN_COUNT_BITS + 32;

   // CORDIC datapath width, angle accumulator width
   localparam int CW = 34;
   localparam int ZW = 33;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032875;
   localparam logic signed [CW-1:0] Q30_ONE     = 34'sd1073741824;
   localparam logic [4:0]           STEP_LAST   = 5'(SINCOS_STEPS - 1);

   // CSR map, index = paddr[4:2]
   localparam int         CSR_ADDR_BITS       = 5;
   localparam logic [2:0] REG_CENTER_X        = 3'd0;
   localparam logic [2:0] REG_CENTER_Y        = 3'd1;
   localparam logic [2:0] REG_CENTER_Z        = 3'd2;
   localparam logic [2:0] REG_RADIUS_PER_TURN = 3'd3;
   localparam logic [2:0] REG_PHASE_INCREMENT = 3'd4;
   localparam logic [2:0] REG_RADIUS_LIMIT    = 3'd5;

   // atan(2^-i) in turns, Q2.30 of a quarter turn scale
   localparam logic [31:0] ARC_TABLE [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RAD_TURN,
      ST_RAD_SUM,
      ST_NXT_TURN,
      ST_NXT_SUM,
      ST_COR_FULL,
      ST_WAIT_FULL,
      ST_COR_HALF,
      ST_WAIT_HALF,
      ST_MUL_X,
      ST_MUL_Y,
      ST_FINAL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] angle;
   } cor_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] sin_val;
      logic signed [31:0] cos_val;
   } cor_rsp_type;

endpackage

// File: hw/rtl/spiral_waypoint_generator.sv
// ----------------------------------------------------------------------------
// spiral_waypoint_generator
// Emits one waypoint of an Archimedean spiral per request beat.
// ----------------------------------------------------------------------------
//  channel | ports                         | beat on
//  --------+-------------------------------+------------------------------
//  req     | req_valid/ready, req_restart  | req_valid & req_ready
//  rsp     | rsp_valid/ready, rsp_* fields | rsp_valid & rsp_ready
//  csr     | APB: psel/penable/pwrite/...  | psel & penable & pwrite
//
//  A point passes CHECK, the radius and next-step states, two CORDIC passes
//  (on the phase fraction and on half the phase) and six passes through the
//  shared 32x32 multiplier before OUT loads the rsp register. Empty or
//  finished paths go from CHECK straight to OUT, a radius over the limit
//  from RAD_SUM. req_ready is high only in IDLE; a new request is taken
//  while the previous result still waits in the rsp register, and the FSM
//  stalls in OUT while that register is full and rsp_ready is low.
//  Synchronous reset clears phase, finished flag, FSM and rsp valid flag,
//  and loads the configuration registers with their reset values.
// ----------------------------------------------------------------------------
module spiral_waypoint_generator (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_restart,
   // result
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_point_x,
   output logic signed [31:0]                rsp_point_y,
   output logic signed [31:0]                rsp_point_z,
   output logic signed [31:0]                rsp_heading_qz,
   output logic signed [31:0]                rsp_heading_qw,
   output logic                              rsp_point_valid,
   output logic                              rsp_last_point,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [swg_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import swg_pkg::*;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [31:0] center_x_ff, center_x_in;
   logic [31:0] center_y_ff, center_y_in;
   logic [31:0] center_z_ff, center_z_in;
   logic [31:0] rpt_ff, rpt_in;     // radius per turn
   logic [31:0] inc_ff, inc_in;     // phase increment
   logic [31:0] limit_ff, limit_in; // radius limit
   logic        csr_wr;
   logic [2:0]  csr_idx;

   // ------------------------------------------------------------------
   // Sequencer and datapath state
   // ------------------------------------------------------------------
   state_type              state_ff, state_in;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic                   finished_ff, finished_in;
   logic [31:0]            acc_ff, acc_in;
   logic [RAD_BITS-1:0]    rad_ff, rad_in;
   logic                   last_ff, last_in;
   logic                   ok_ff, ok_in;
   logic signed [31:0]     sin_ff, sin_in, cos_ff, cos_in;
   logic signed [31:0]     hsin_ff, hsin_in, hcos_ff, hcos_in;
   logic signed [31:0]     px_ff, px_in, py_ff, py_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]     o_x_ff, o_x_in, o_y_ff, o_y_in, o_z_ff, o_z_in;
   logic signed [31:0]     o_qz_ff, o_qz_in, o_qw_ff, o_qw_in;
   logic                   o_pv_ff, o_pv_in, o_last_ff, o_last_in;

   logic                   req_beat, out_free, empty_path, over_lim, next_over;
   logic [PHASE_BITS:0]    next_phase;
   logic [RAD_BITS-1:0]    rad_sum, limit_ext;
   logic [31:0]            mul_a, mul_b;
   logic [63:0]            prod;
   cor_req_type            cor_req;
   cor_rsp_type            cor_rsp;

   // |v| of a Q2.30 value, fits 31 bits
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? 32'(-v) : 32'(v);
      return r;
   endfunction

   // center + round_half_away(rad*|t| / 2^30) with sign, saturated to 32 bits
   function automatic logic signed [31:0] place(input logic signed [31:0] ctr,
                                               input logic [63:0] p,
                                               input logic neg);
      logic [63:0]        r;
      logic signed [35:0] m;
      logic signed [35:0] s;
      logic signed [31:0] q;
      r = p + 64'd536870912;
      m = signed'({2'b00, r[63:30]});
      if (neg) begin
         m = -m;
      end
      s = {{4{ctr[31]}}, ctr} + m;
      if (s > 36'sd2147483647) begin
         q = 32'sh7FFF_FFFF;
      end else if (s < -36'sd2147483648) begin
         q = 32'sh8000_0000;
      end else begin
         q = 32'(s);
      end
      return q;
   endfunction

   // ------------------------------------------------------------------
   // Shared units
   // ------------------------------------------------------------------
   swg_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   swg_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .cor_req (cor_req),
      .cor_rsp (cor_rsp)
   );

   // ------------------------------------------------------------------
   // CSR port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_BITS-1:2];

   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      center_z_in = center_z_ff;
      rpt_in      = rpt_ff;
      inc_in      = inc_ff;
      limit_in    = limit_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_CENTER_X:        center_x_in = csr_pwdata;
            REG_CENTER_Y:        center_y_in = csr_pwdata;
            REG_CENTER_Z:        center_z_in = csr_pwdata;
            REG_RADIUS_PER_TURN: rpt_in      = csr_pwdata;
            REG_PHASE_INCREMENT: inc_in      = csr_pwdata;
            REG_RADIUS_LIMIT:    limit_in    = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_CENTER_X:        csr_prdata = center_x_ff;
         REG_CENTER_Y:        csr_prdata = center_y_ff;
         REG_CENTER_Z:        csr_prdata = center_z_ff;
         REG_RADIUS_PER_TURN: csr_prdata = rpt_ff;
         REG_PHASE_INCREMENT: csr_prdata = inc_ff;
         REG_RADIUS_LIMIT:    csr_prdata = limit_ff;
         default:             csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Shared combinational terms
   // ------------------------------------------------------------------
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_beat   = req_valid & req_ready;
   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign empty_path = (rpt_ff == '0) | (inc_ff == '0) | (limit_ff == '0);
   // one extra bit catches turn counter overflow
   assign next_phase = {1'b0, phase_ff} + (PHASE_BITS + 1)'(inc_ff);
   // radius = rpt*turns + hi32(rpt*frac); acc holds the high word
   assign rad_sum    = RAD_BITS'(acc_ff) + prod[RAD_BITS-1:0];
   assign limit_ext  = RAD_BITS'(limit_ff);
   assign over_lim   = rad_sum > limit_ext;
   assign next_over  = next_phase[PHASE_BITS];

   // multiplier operand select
   always_comb begin
      mul_a = rpt_ff;
      mul_b = '0;
      case (state_ff)
         ST_CHECK:    mul_b = phase_ff[FRAC_BITS-1:0];
         ST_RAD_TURN: mul_b = 32'(phase_ff[PHASE_BITS-1:FRAC_BITS]);
         ST_RAD_SUM:  mul_b = next_phase[FRAC_BITS-1:0];
         ST_NXT_TURN: mul_b = 32'(next_phase[PHASE_BITS-1:FRAC_BITS]);
         ST_MUL_X: begin
            mul_a = rad_ff[31:0];
            mul_b = mag32(cos_ff);
         end
         ST_MUL_Y: begin
            mul_a = rad_ff[31:0];
            mul_b = mag32(sin_ff);
         end
         default: ;
      endcase
   end

   // CORDIC runs on the phase fraction, then on half of the phase
   always_comb begin
      cor_req.start = (state_ff == ST_COR_FULL) | (state_ff == ST_COR_HALF);
      cor_req.angle = (state_ff == ST_COR_HALF) ? phase_ff[FRAC_BITS:1]
                                                : phase_ff[FRAC_BITS-1:0];
   end

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_beat) state_in = ST_CHECK;
         ST_CHECK:     state_in = (empty_path | finished_ff) ? ST_OUT : ST_RAD_TURN;
         ST_RAD_TURN:  state_in = ST_RAD_SUM;
         ST_RAD_SUM:   state_in = over_lim ? ST_OUT : ST_NXT_TURN;
         ST_NXT_TURN:  state_in = ST_NXT_SUM;
         ST_NXT_SUM:   state_in = ST_COR_FULL;
         ST_COR_FULL:  state_in = ST_WAIT_FULL;
         ST_WAIT_FULL: if (cor_rsp.done) state_in = ST_COR_HALF;
         ST_COR_HALF:  state_in = ST_WAIT_HALF;
         ST_WAIT_HALF: if (cor_rsp.done) state_in = ST_MUL_X;
         ST_MUL_X:     state_in = ST_MUL_Y;
         ST_MUL_Y:     state_in = ST_FINAL;
         ST_FINAL:     state_in = ST_OUT;
         ST_OUT:       if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath updates
   // ------------------------------------------------------------------
   always_comb begin
      phase_in    = phase_ff;
      finished_in = finished_ff;
      acc_in      = acc_ff;
      rad_in      = rad_ff;
      last_in     = last_ff;
      ok_in       = ok_ff;
      sin_in      = sin_ff;
      cos_in      = cos_ff;
      hsin_in     = hsin_ff;
      hcos_in     = hcos_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat && req_restart) begin
               phase_in    = '0;
               finished_in = 1'b0;
            end
         end
         ST_CHECK:    ok_in = 1'b0;
         ST_RAD_TURN: acc_in = prod[63:32];
         ST_RAD_SUM: begin
            rad_in = rad_sum;
            // limit lowered below the current radius ends the path
            if (over_lim) begin
               finished_in = 1'b1;
            end
         end
         ST_NXT_TURN: acc_in = prod[63:32];
         ST_NXT_SUM:  last_in = next_over | over_lim;
         ST_WAIT_FULL: begin
            if (cor_rsp.done) begin
               sin_in = cor_rsp.sin_val;
               cos_in = cor_rsp.cos_val;
            end
         end
         ST_WAIT_HALF: begin
            if (cor_rsp.done) begin
               hsin_in = cor_rsp.sin_val;
               hcos_in = cor_rsp.cos_val;
            end
         end
         ST_MUL_Y:    px_in = place(signed'(center_x_ff), prod, cos_ff[31]);
         ST_FINAL: begin
            py_in = place(signed'(center_y_ff), prod, sin_ff[31]);
            ok_in = 1'b1;
            if (last_ff) begin
               finished_in = 1'b1;
            end else begin
               phase_in = next_phase[PHASE_BITS-1:0];
            end
         end
         default: ;
      endcase
   end

   // result register; an invalid point carries all-zero fields
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      o_x_in       = o_x_ff;
      o_y_in       = o_y_ff;
      o_z_in       = o_z_ff;
      o_qz_in      = o_qz_ff;
      o_qw_in      = o_qw_ff;
      o_pv_in      = o_pv_ff;
      o_last_in    = o_last_ff;
      if (state_ff == ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
         o_pv_in      = ok_ff;
         o_last_in    = ok_ff & last_ff;
         o_x_in       = ok_ff ? px_ff : '0;
         o_y_in       = ok_ff ? py_ff : '0;
         o_z_in       = ok_ff ? signed'(center_z_ff) : '0;
         o_qz_in      = ok_ff ? hsin_ff : '0;
         o_qw_in      = ok_ff ? hcos_ff : '0;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         center_z_ff  <= '0;
         rpt_ff       <= 32'd655360;
         inc_ff       <= 32'd59652324;
         limit_ff     <= 32'd6553600;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
         center_x_ff  <= center_x_in;
         center_y_ff  <= center_y_in;
         center_z_ff  <= center_z_in;
         rpt_ff       <= rpt_in;
         inc_ff       <= inc_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      rad_ff    <= rad_in;
      last_ff   <= last_in;
      ok_ff     <= ok_in;
      sin_ff    <= sin_in;
      cos_ff    <= cos_in;
      hsin_ff   <= hsin_in;
      hcos_ff   <= hcos_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      o_x_ff    <= o_x_in;
      o_y_ff    <= o_y_in;
      o_z_ff    <= o_z_in;
      o_qz_ff   <= o_qz_in;
      o_qw_ff   <= o_qw_in;
      o_pv_ff   <= o_pv_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = o_x_ff;
   assign rsp_point_y     = o_y_ff;
   assign rsp_point_z     = o_z_ff;
   assign rsp_heading_qz  = o_qz_ff;
   assign rsp_heading_qw  = o_qw_ff;
   assign rsp_point_valid = o_pv_ff;
   assign rsp_last_point  = o_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_point_valid |-> rsp_point_x == 0 && rsp_point_y == 0 &&
      rsp_point_z == 0 && rsp_heading_qz == 0 && rsp_heading_qw == 0 && !rsp_last_point)
      else $error("invalid point with nonzero fields");

   a_cordic_done_waited: assert property (@(posedge clock) disable iff (reset)
      cor_rsp.done |-> state_ff == ST_WAIT_FULL || state_ff == ST_WAIT_HALF)
      else $error("CORDIC finished outside a wait state");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_heading_qz <= 32'sd1073741824 &&
      rsp_heading_qz >= -32'sd1073741824 && rsp_heading_qw <= 32'sd1073741824 &&
      rsp_heading_qw >= -32'sd1073741824)
      else $error("heading component out of range");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_finished_holds_phase: assert property (@(posedge clock) disable iff (reset)
      finished_ff && state_ff != ST_IDLE |=> $stable(phase_ff))
      else $error("phase advanced on a finished path");

endmodule

// File: hw/rtl/swg_mul.sv
// ----------------------------------------------------------------------------
// swg_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module swg_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] prod_ff
);
   logic [63:0] prod_in;

   assign prod_in = {32'd0, mul_a} * {32'd0, mul_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: hw/rtl/swg_cordic.sv
// ----------------------------------------------------------------------------
// swg_cordic
// Iterative rotation-mode CORDIC, one step per cycle, quadrant folded.
// ----------------------------------------------------------------------------
module swg_cordic (
   input  logic                 clock,
   input  logic                 reset,
   input  swg_pkg::cor_req_type cor_req,
   output swg_pkg::cor_rsp_type cor_rsp
);
   import swg_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [4:0]           step_ff, step_in;
   logic [1:0]           quad_ff, quad_in;
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic signed [31:0]   sin_ff, sin_in, cos_ff, cos_in;

   logic signed [CW-1:0] dx, dy, cx_nx, cy_nx;
   logic signed [ZW-1:0] arc, z_nx;
   logic signed [31:0]   cxc, cyc;

   function automatic logic signed [31:0] clamp_q30(input logic signed [CW-1:0] v);
      logic signed [31:0] r;
      if (v > Q30_ONE) begin
         r = 32'(Q30_ONE);
      end else if (v < -Q30_ONE) begin
         r = 32'(-Q30_ONE);
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

   always_comb begin
      dx  = cy_ff >>> step_ff;
      dy  = cx_ff >>> step_ff;
      arc = signed'({1'b0, ARC_TABLE[step_ff]});
      if (!z_ff[ZW-1]) begin
         cx_nx = cx_ff - dx;
         cy_nx = cy_ff + dy;
         z_nx  = z_ff - arc;
      end else begin
         cx_nx = cx_ff + dx;
         cy_nx = cy_ff - dy;
         z_nx  = z_ff + arc;
      end
      cxc = clamp_q30(cx_nx);
      cyc = clamp_q30(cy_nx);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quad_in = quad_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      z_in    = z_ff;
      sin_in  = sin_ff;
      cos_in  = cos_ff;
      if (cor_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quad_in = cor_req.angle[31:30];
         cx_in   = CORDIC_GAIN;
         cy_in   = '0;
         z_in    = signed'({3'b000, cor_req.angle[29:0]});
      end else if (busy_ff) begin
         cx_in   = cx_nx;
         cy_in   = cy_nx;
         z_in    = z_nx;
         step_in = step_ff + 5'd1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            case (quad_ff)
               2'd0: begin
                  cos_in = cxc;
                  sin_in = cyc;
               end
               2'd1: begin
                  cos_in = -cyc;
                  sin_in = cxc;
               end
               2'd2: begin
                  cos_in = -cxc;
                  sin_in = -cyc;
               end
               default: begin
                  cos_in = cyc;
                  sin_in = -cxc;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quad_ff <= quad_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      z_ff    <= z_in;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
   end

   assign cor_rsp.done    = done_ff;
   assign cor_rsp.sin_val = sin_ff;
   assign cor_rsp.cos_val = cos_ff;

endmodule

// File: verif/spiral_waypoint_generator_checker.sv
// ----------------------------------------------------------------------------
// spiral_waypoint_checker
// Watches the req, rsp and csr ports of the spiral waypoint generator, keeps
// its own copy of the spiral state, predicts each waypoint and compares
// every rsp beat against the oldest prediction.
// ----------------------------------------------------------------------------
module spiral_waypoint_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_restart,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [31:0]                rsp_point_x,
   input  logic signed [31:0]                rsp_point_y,
   input  logic signed [31:0]                rsp_point_z,
   input  logic signed [31:0]                rsp_heading_qz,
   input  logic signed [31:0]                rsp_heading_qw,
   input  logic                              rsp_point_valid,
   input  logic                              rsp_last_point,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [swg_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   input  logic                              csr_pready,
   output int unsigned                       mismatch_count,
   output int unsigned                       points_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import swg_pkg::*;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] heading_qz;
      logic signed [31:0] heading_qw;
      logic               point_valid;
      logic               last_point;
   } waypoint_type;

   localparam logic [31:0] TURN_GROWTH_RESET = 32'd655360;
   localparam logic [31:0] PHASE_STEP_RESET  = 32'd59652324;
   localparam logic [31:0] RADIUS_CAP_RESET  = 32'd6553600;
   localparam longint      S32_MAX           = 64'sd2147483647;
   localparam longint      S32_MIN           = -64'sd2147483648;

   logic signed [31:0]    center_x;
   logic signed [31:0]    center_y;
   logic signed [31:0]    center_z;
   logic [31:0]           turn_growth;
   logic [31:0]           phase_step;
   logic [31:0]           radius_cap;
   logic [PHASE_BITS-1:0] phase_acc;
   logic                  path_done;
   waypoint_type          pending_waypoints[$];
   int unsigned           errs;

   // Q16.16 radius at a phase: whole turns times growth plus the fraction part
   function automatic longint unsigned radius_at_phase(input logic [PHASE_BITS-1:0] ph);
      longint unsigned rpt;
      longint unsigned turns;
      longint unsigned frac;
      rpt   = turn_growth;
      turns = ph >> FRAC_BITS;
      frac  = ph[FRAC_BITS-1:0];
      return rpt * turns + ((rpt * frac) >> 32);
   endfunction

   function automatic longint clamp_unit(input longint v);
      if (v > longint'(Q30_ONE)) return longint'(Q30_ONE);
      if (v < -longint'(Q30_ONE)) return -longint'(Q30_ONE);
      return v;
   endfunction

   // rotation CORDIC on the low 30 bits, quadrant from the top two
   function automatic void cordic_sin_cos(input logic [31:0] ang, output longint sin_v,
                                          output longint cos_v);
      longint cx;
      longint cy;
      longint z;
      longint dx;
      longint dy;
      longint step_arc;
      cx = longint'(CORDIC_GAIN);
      cy = 0;
      z  = {34'd0, ang[29:0]};
      for (int i = 0; i < SINCOS_STEPS && i < 32; i++) begin
         dx       = cy >>> i;
         dy       = cx >>> i;
         step_arc = {32'd0, ARC_TABLE[i]};
         if (z >= 0) begin
            cx = cx - dx;
            cy = cy + dy;
            z  = z - step_arc;
         end else begin
            cx = cx + dx;
            cy = cy - dy;
            z  = z + step_arc;
         end
      end
      cx = clamp_unit(cx);
      cy = clamp_unit(cy);
      case (ang[31:30])
         2'd0: begin
            cos_v = cx;
            sin_v = cy;
         end
         2'd1: begin
            cos_v = -cy;
            sin_v = cx;
         end
         2'd2: begin
            cos_v = -cx;
            sin_v = -cy;
         end
         default: begin
            cos_v = cy;
            sin_v = -cx;
         end
      endcase
   endfunction

   // radius times Q2.30 trig value, rounded half away from zero
   function automatic longint scaled_round(input longint unsigned rad, input longint t);
      longint unsigned mag;
      longint unsigned v;
      mag = (t < 0) ? -t : t;
      v   = (rad * mag + (64'd1 << 29)) >> 30;
      return (t < 0) ? -$signed(v) : $signed(v);
   endfunction

   function automatic logic [31:0] clip_s32(input longint v);
      if (v > S32_MAX) return 32'h7FFF_FFFF;
      if (v < S32_MIN) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // one spiral step: updates phase_acc and path_done, returns the waypoint
   function automatic waypoint_type advance_spiral(input logic restart);
      waypoint_type          wp;
      longint unsigned       rad;
      logic [PHASE_BITS:0]   nxt;
      logic                  is_last;
      longint                s;
      longint                c;
      longint                hs;
      longint                hc;
      wp = '0;
      if (restart) begin
         phase_acc = '0;
         path_done = 1'b0;
      end
      if (turn_growth == 0 || phase_step == 0 || radius_cap == 0) return wp;
      if (path_done) return wp;
      rad = radius_at_phase(phase_acc);
      if (rad > radius_cap) begin
         path_done = 1'b1;
         return wp;
      end
      nxt     = {1'b0, phase_acc} + (PHASE_BITS + 1)'(phase_step);
      is_last = nxt[PHASE_BITS] || (radius_at_phase(nxt[PHASE_BITS-1:0]) > radius_cap);
      cordic_sin_cos(phase_acc[31:0], s, c);
      cordic_sin_cos(phase_acc[32:1], hs, hc);
      wp.point_x     = clip_s32(longint'(center_x) + scaled_round(rad, c));
      wp.point_y     = clip_s32(longint'(center_y) + scaled_round(rad, s));
      wp.point_z     = center_z;
      wp.heading_qz  = hs[31:0];
      wp.heading_qw  = hc[31:0];
      wp.point_valid = 1'b1;
      wp.last_point  = is_last;
      if (is_last) path_done = 1'b1;
      else phase_acc = nxt[PHASE_BITS-1:0];
      return wp;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         errs++;
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      end
   endfunction

   always @(posedge clock) begin : watch
      waypoint_type want;
      if (reset) begin
         center_x    = '0;
         center_y    = '0;
         center_z    = '0;
         turn_growth = TURN_GROWTH_RESET;
         phase_step  = PHASE_STEP_RESET;
         radius_cap  = RADIUS_CAP_RESET;
         phase_acc   = '0;
         path_done   = 1'b0;
         pending_waypoints.delete();
         errs        = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_waypoints.size() == 0) begin
               errs++;
               $error("rsp beat with no waypoint expected");
            end else begin
               want = pending_waypoints.pop_front();
               check_field("point_x", want.point_x, rsp_point_x);
               check_field("point_y", want.point_y, rsp_point_y);
               check_field("point_z", want.point_z, rsp_point_z);
               check_field("heading_qz", want.heading_qz, rsp_heading_qz);
               check_field("heading_qw", want.heading_qw, rsp_heading_qw);
               check_field("point_valid", {31'd0, want.point_valid},
                           {31'd0, rsp_point_valid});
               check_field("last_point", {31'd0, want.last_point},
                           {31'd0, rsp_last_point});
            end
         end
         // prediction uses the registers as they were before this edge
         if (req_valid && req_ready)
            pending_waypoints.insert(pending_waypoints.size(),
                                     advance_spiral(req_restart));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_CENTER_X:        center_x    = csr_pwdata;
               REG_CENTER_Y:        center_y    = csr_pwdata;
               REG_CENTER_Z:        center_z    = csr_pwdata;
               REG_RADIUS_PER_TURN: turn_growth = csr_pwdata;
               REG_PHASE_INCREMENT: phase_step  = csr_pwdata;
               REG_RADIUS_LIMIT:    radius_cap  = csr_pwdata;
               default: ;
            endcase
         end
      end
      mismatch_count <= errs;
      points_pending <= pending_waypoints.size();
   end

endmodule

// File: verif/spiral_waypoint_generator_tb.sv
// ----------------------------------------------------------------------------
// spiral_waypoint_generator_tb
// Drives restart/advance beats and CSR writes into the spiral waypoint
// generator, with random idle gaps on both channels; a checker beside the
// block predicts every waypoint and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module spiral_waypoint_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import swg_pkg::*;

   localparam int unsigned RANDOM_POINTS    = 600;
   localparam int unsigned LONG_HOLD_CYCLES = 500;  // rsp held off, fills the block
   localparam int unsigned SETTLE_CYCLES    = 100;  // beyond the point latency
   localparam int unsigned TIMEOUT_NS       = 10_000_000;

   // register values after reset, restored by the directed part
   localparam logic [31:0] STEP_10M     = 32'd655360;    // 10.0 per turn
   localparam logic [31:0] STEP_5DEG    = 32'd59652324;  // 5 degrees
   localparam logic [31:0] CAP_100M     = 32'd6553600;   // 100.0
   localparam logic [31:0] S32_MAX      = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN      = 32'h8000_0000;
   localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_restart = 1'b0;
   logic                     rsp_ready   = 1'b0;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [31:0]              csr_pwdata  = '0;

   logic                     req_ready;
   logic                     rsp_valid;
   logic signed [31:0]       rsp_point_x;
   logic signed [31:0]       rsp_point_y;
   logic signed [31:0]       rsp_point_z;
   logic signed [31:0]       rsp_heading_qz;
   logic signed [31:0]       rsp_heading_qw;
   logic                     rsp_point_valid;
   logic                     rsp_last_point;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   int unsigned              mismatch_count;
   int unsigned              points_pending;
   int unsigned              items_sent    = 0;
   bit                       steady_flow   = 1'b0;  // no idle gaps on either side
   bit                       long_hold_req = 1'b0;  // ask the sink for one long hold-off

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   spiral_waypoint_generator i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_z     (rsp_point_z),
      .rsp_heading_qz  (rsp_heading_qz),
      .rsp_heading_qw  (rsp_heading_qw),
      .rsp_point_valid (rsp_point_valid),
      .rsp_last_point  (rsp_last_point),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   spiral_waypoint_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_z     (rsp_point_z),
      .rsp_heading_qz  (rsp_heading_qz),
      .rsp_heading_qw  (rsp_heading_qw),
      .rsp_point_valid (rsp_point_valid),
      .rsp_last_point  (rsp_last_point),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .mismatch_count  (mismatch_count),
      .points_pending  (points_pending)
   );

   // Idle gap length: mostly none, some short, a few long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady_flow) return 0;
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 4);
      return $urandom_range(12, 60);
   endfunction

   // Center coordinate: the two rails, the origin, or anything.
   function automatic logic [31:0] pick_center();
      case ($urandom_range(0, 7))
         0:       return S32_MAX;
         1:       return S32_MIN;
         2:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // APB write: setup cycle, then access cycle; the register takes the value
   // at the edge where psel, penable, pwrite and pready are all high.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic write_config(input logic [31:0] cx, input logic [31:0] cy,
                               input logic [31:0] cz, input logic [31:0] rpt,
                               input logic [31:0] inc, input logic [31:0] lim);
      csr_write(REG_CENTER_X, cx);
      csr_write(REG_CENTER_Y, cy);
      csr_write(REG_CENTER_Z, cz);
      csr_write(REG_RADIUS_PER_TURN, rpt);
      csr_write(REG_PHASE_INCREMENT, inc);
      csr_write(REG_RADIUS_LIMIT, lim);
   endtask

   // One req beat. Valid is only dropped when a gap follows, so back-to-back
   // beats keep it high with a single assignment per edge. req_ready is taken
   // at the falling edge, where it is settled and equals what the next rising
   // edge sees.
   task automatic send_point(input bit restart);
      int unsigned gap;
      bit          taken;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      items_sent++;
   endtask

   // Sender pause: hold valid low until every predicted waypoint has come out.
   // Every beat yields a result, so the block is idle once this returns.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (points_pending != 0);
      @(posedge clock);
   endtask

   // Result sink: ready runs of random length, random gaps, and one long
   // hold-off on request while the sender keeps offering beats.
   initial begin : sink
      int unsigned run_len;
      int unsigned gap_len;
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         run_len = $urandom_range(1, 24);
         rsp_ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         gap_len = pick_gap();
         if (gap_len != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [31:0]     rpt_val;
      logic [31:0]     inc_val;
      logic [31:0]     lim_val;
      longint unsigned span;
      int unsigned     random_goal;
      int unsigned     phase_idx;
      int unsigned     seq_count;
      int unsigned     seq_len;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---------------------------------------------------------
      // reset registers: start of path, two advances, restart mid-path
      send_point(1'b1);
      send_point(1'b0);
      send_point(1'b0);
      send_point(1'b1);
      wait_drained();

      // extreme centers and widest steps: quarter-turn phase, full-scale
      // radius growth, so x/y saturate on both rails; the fifth point ends the
      // path on the radius cap and the two after it are finished-path beats
      write_config(S32_MAX, S32_MIN, S32_MAX, ALL_ONES, 32'h4000_0000, ALL_ONES);
      send_point(1'b1);
      repeat (6) send_point(1'b0);
      wait_drained();

      // empty path from each of the three zero registers
      csr_write(REG_RADIUS_PER_TURN, '0);
      send_point(1'b1);
      send_point(1'b0);
      wait_drained();
      csr_write(REG_RADIUS_PER_TURN, STEP_10M);
      csr_write(REG_PHASE_INCREMENT, '0);
      send_point(1'b1);
      wait_drained();
      csr_write(REG_PHASE_INCREMENT, STEP_5DEG);
      csr_write(REG_RADIUS_LIMIT, '0);
      send_point(1'b1);
      wait_drained();

      // cap lowered below the current radius mid-path: invalid, then finished
      // until the restart, whose next step is already past the cap
      write_config(32'h0010_0000, 32'hFFF0_0000, 32'h0002_8000, STEP_10M, 32'h2000_0000,
                   CAP_100M);
      send_point(1'b1);
      repeat (4) send_point(1'b0);
      wait_drained();
      csr_write(REG_RADIUS_LIMIT, 32'h0001_0000);
      send_point(1'b0);
      send_point(1'b0);
      send_point(1'b1);

      // --- random phases ----------------------------------------------------
      random_goal = items_sent + RANDOM_POINTS;
      phase_idx   = 0;
      while (items_sent < random_goal) begin
         wait_drained();

         case ($urandom_range(0, 19))
            0:             rpt_val = '0;
            1:             rpt_val = ALL_ONES;
            2:             rpt_val = 32'd1;
            3, 4, 5, 6, 7: rpt_val = $urandom;
            default:       rpt_val = $urandom_range(32'h0000_1000, 32'h0040_0000);
         endcase
         case ($urandom_range(0, 19))
            0:             inc_val = '0;
            1:             inc_val = ALL_ONES;
            2:             inc_val = 32'd1;
            3, 4, 5, 6, 7: inc_val = $urandom;
            default:       inc_val = ALL_ONES / $urandom_range(3, 48);
         endcase
         // cap a few turns out so that paths end inside a phase
         case ($urandom_range(0, 19))
            0:       lim_val = '0;
            1:       lim_val = ALL_ONES;
            default: begin
               span    = rpt_val * $urandom_range(0, 5) + $urandom_range(0, rpt_val);
               lim_val = (span > 64'h0000_0000_FFFF_FFFF) ? ALL_ONES : span[31:0];
            end
         endcase
         write_config(pick_center(), pick_center(), pick_center(), rpt_val, inc_val, lim_val);

         steady_flow = (phase_idx == 2) || (phase_idx % 5 == 3);
         if (phase_idx == 2) begin
            // sink stalls while beats keep coming: the block fills and
            // drops req_ready
            long_hold_req = 1'b1;
            repeat (12) send_point(1'b0);
         end

         seq_count = $urandom_range(1, 4);
         repeat (seq_count) begin
            seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 24);
            case ($urandom_range(0, 9))
               0: repeat ($urandom_range(1, 6)) send_point($urandom_range(0, 1));
               1: repeat (seq_len) send_point(1'b0);  // carry on under new registers
               default: begin
                  send_point(1'b1);
                  repeat (seq_len) send_point(1'b0);
               end
            endcase
         end
         phase_idx++;
      end

      // --- wrap-up ----------------------------------------------------------
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0 && points_pending == 0)
         $display("spiral_waypoint_generator_tb: done, clean");
      else
         $display("spiral_waypoint_generator_tb: done, errors");
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("spiral_waypoint_generator_tb: done, errors");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/swg_pkg.sv
hw/rtl/swg_mul.sv
hw/rtl/swg_cordic.sv
hw/rtl/spiral_waypoint_generator.sv
verif/spiral_waypoint_generator_checker.sv
verif/spiral_waypoint_generator_tb.sv
